// ===== rtl/anc_pkg.sv =====
// Shared types and constants for the ALU with nibble carry flags.
`default_nettype none

package anc_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned OP_W   = 4;
   localparam int unsigned FLAG_W = 4;

   localparam int unsigned FLAG_Z_BIT = 3;
   localparam int unsigned FLAG_N_BIT = 2;
   localparam int unsigned FLAG_H_BIT = 1;
   localparam int unsigned FLAG_C_BIT = 0;

   typedef enum logic [OP_W-1:0] {
      OP_ADD       = 4'd0,
      OP_ADC       = 4'd1,
      OP_SUB       = 4'd2,
      OP_SBC       = 4'd3,
      OP_INC8      = 4'd4,
      OP_DEC8      = 4'd5,
      OP_ADD16     = 4'd6,
      OP_SUB16     = 4'd7,
      OP_INC16     = 4'd8,
      OP_DEC16     = 4'd9,
      OP_INC8_NOFL = 4'd10,
      OP_DEC8_NOFL = 4'd11
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [WORD_W-1:0] operand_a;
      logic [WORD_W-1:0] operand_b;
   } item_in_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_value;
      logic [FLAG_W-1:0] flags_out;
   } item_out_type;

endpackage

`default_nettype wire

// ===== rtl/anc_if.sv =====
// Handshake channels for the ALU request and response items.
`default_nettype none

interface anc_req_if;
   logic                         valid;
   logic                         ready;
   logic [anc_pkg::OP_W-1:0]     req_type;
   logic [anc_pkg::WORD_W-1:0]   operand_a;
   logic [anc_pkg::WORD_W-1:0]   operand_b;

   modport source (output valid, output req_type, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input req_type, input operand_a, input operand_b,
                   output ready);
endinterface

interface anc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [anc_pkg::WORD_W-1:0]   result_value;
   logic [anc_pkg::FLAG_W-1:0]   flags_out;

   modport source (output valid, output result_value, output flags_out, input ready);
   modport sink   (input valid, input result_value, input flags_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/anc_core.sv =====
// Combinational ALU datapath: result and next flag value for one item.
`default_nettype none

module anc_core (
   input  anc_pkg::item_in_type       item,
   input  logic [anc_pkg::FLAG_W-1:0] flags_cur,
   output anc_pkg::item_out_type      outcome
);

   logic [anc_pkg::BYTE_W-1:0] a8;
   logic [anc_pkg::BYTE_W-1:0] b8;
   logic                       cin;
   logic                       carry_en;
   logic [anc_pkg::BYTE_W:0]   sum9;
   logic [4:0]                 half_sum;
   logic [anc_pkg::BYTE_W:0]   diff9;
   logic [4:0]                 half_diff;
   logic [anc_pkg::WORD_W:0]   sum17;
   logic [12:0]                sum13;
   logic [anc_pkg::WORD_W:0]   diff17;
   logic [12:0]                diff13;
   logic [anc_pkg::BYTE_W-1:0] inc_a8;
   logic [anc_pkg::BYTE_W-1:0] dec_a8;
   logic [anc_pkg::BYTE_W-1:0] inc_b8;
   logic [anc_pkg::BYTE_W-1:0] dec_b8;
   anc_pkg::op_type            op;

   assign op  = anc_pkg::op_type'(item.req_type);
   assign a8  = item.operand_a[anc_pkg::BYTE_W-1:0];
   assign b8  = item.operand_b[anc_pkg::BYTE_W-1:0];
   assign carry_en = (op == anc_pkg::OP_ADC) || (op == anc_pkg::OP_SBC);
   assign cin = carry_en & flags_cur[anc_pkg::FLAG_C_BIT];

   assign sum9      = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
   assign half_sum  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
   assign diff9     = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
   assign half_diff = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};

   assign sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
   assign sum13  = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
   assign diff17 = {1'b0, item.operand_a} - {1'b0, item.operand_b};
   assign diff13 = {1'b0, item.operand_a[11:0]} - {1'b0, item.operand_b[11:0]};

   assign inc_a8 = a8 + 8'd1;
   assign dec_a8 = a8 - 8'd1;
   assign inc_b8 = b8 + 8'd1;
   assign dec_b8 = b8 - 8'd1;

   always_comb begin
      outcome.result_value = '0;
      outcome.flags_out    = flags_cur;
      case (op)
         anc_pkg::OP_ADD, anc_pkg::OP_ADC: begin
            outcome.result_value = {8'd0, sum9[7:0]};
            outcome.flags_out    = {(sum9[7:0] == 8'd0), 1'b0, half_sum[4], sum9[8]};
         end
         anc_pkg::OP_SUB, anc_pkg::OP_SBC: begin
            outcome.result_value = {8'd0, diff9[7:0]};
            outcome.flags_out    = {(diff9[7:0] == 8'd0), 1'b1, half_diff[4], diff9[8]};
         end
         anc_pkg::OP_INC8: begin
            outcome.result_value = {8'd0, inc_a8};
            outcome.flags_out    = {(inc_a8 == 8'd0), 1'b0, (a8[3:0] == 4'hF),
                                    flags_cur[anc_pkg::FLAG_C_BIT]};
         end
         anc_pkg::OP_DEC8: begin
            outcome.result_value = {8'd0, dec_a8};
            outcome.flags_out    = {(dec_a8 == 8'd0), 1'b1, (a8[3:0] == 4'h0),
                                    flags_cur[anc_pkg::FLAG_C_BIT]};
         end
         anc_pkg::OP_ADD16: begin
            outcome.result_value = sum17[15:0];
            outcome.flags_out    = {flags_cur[anc_pkg::FLAG_Z_BIT], 1'b0, sum13[12], sum17[16]};
         end
         anc_pkg::OP_SUB16: begin
            outcome.result_value = diff17[15:0];
            outcome.flags_out    = {flags_cur[anc_pkg::FLAG_Z_BIT], 1'b1, diff13[12],
                                    diff17[16]};
         end
         anc_pkg::OP_INC16: begin
            outcome.result_value = item.operand_a + 16'd1;
         end
         anc_pkg::OP_DEC16: begin
            outcome.result_value = item.operand_a - 16'd1;
         end
         anc_pkg::OP_INC8_NOFL: begin
            outcome.result_value = {8'd0, inc_b8};
         end
         anc_pkg::OP_DEC8_NOFL: begin
            outcome.result_value = {8'd0, dec_b8};
         end
         default: begin
            outcome.result_value = '0;
            outcome.flags_out    = flags_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/alu_with_nibble_carry_flags_unit.sv =====
// Top level: 8/16-bit ALU with Z, N, H, C flags kept between items.
//
// Usage:
//   req_chan carries an operation code and two 16-bit operands; rsp_chan
//   returns the wrapped result and the flag register after the operation.
//   Every request item produces exactly one response item, in order.
// Path: an accepted request goes into the input register, then into the
//   result register, from which the response item is offered. The flag
//   register updates as an item moves into the result register, so the
//   next item sees its flags.
// Throughput: one item per cycle while rsp_chan.ready stays high; the flag
//   feedback runs through the ALU datapath.
// Stall: when rsp_chan.ready is low the result register holds; an empty
//   input register still takes one more item, then req_chan.ready drops.
// Reset: synchronous, active high; clears both valid bits and the flag
//   register to zero.
`default_nettype none

module alu_with_nibble_carry_flags_unit (
   input  logic             clock,
   input  logic             reset,
   anc_req_if.sink          req_chan,
   anc_rsp_if.source        rsp_chan
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   anc_pkg::item_in_type        in_item_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   anc_pkg::item_out_type       out_item_ff;
   logic [anc_pkg::FLAG_W-1:0]  flag_ff;
   logic [anc_pkg::FLAG_W-1:0]  flag_in;
   anc_pkg::item_out_type       outcome;
   logic                        advance;
   logic                        req_take;

   anc_core u_core (
      .item      (in_item_ff),
      .flags_cur (flag_ff),
      .outcome   (outcome)
   );

   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;
   assign flag_in      = (advance && in_valid_ff) ? outcome.flags_out : flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flag_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flag_ff      <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.req_type  <= req_chan.req_type;
         in_item_ff.operand_a <= req_chan.operand_a;
         in_item_ff.operand_b <= req_chan.operand_b;
      end
      if (advance && in_valid_ff) begin
         out_item_ff <= outcome;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_value = out_item_ff.result_value;
   assign rsp_chan.flags_out    = out_item_ff.flags_out;

endmodule

`default_nettype wire
